// ===== rtl/core/ipd_pkg.sv =====
// Package for the incremental PID controller with deadband.
// Holds register indexes, reset values, term limits and field widths.
// No dependencies; used by incremental_pid_with_deadband.
package ipd_pkg;

  // Field and register widths.
  localparam int MEAS_W    = 16;
  localparam int ERR_W     = 17;
  localparam int INTEG_W   = 18;
  localparam int ACC_W     = 16;
  localparam int DRIVE_W   = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KP           = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KI           = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KD           = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_DIVISOR = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DRIVE    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT       = 3'd7;

  // Register reset values.
  localparam logic [15:0] RST_SETPOINT     = 16'd0;
  localparam logic [15:0] RST_DEADBAND     = 16'd100;
  localparam logic [15:0] RST_KP           = 16'd1;
  localparam logic [7:0]  RST_KI           = 8'd0;
  localparam logic [15:0] RST_KD           = 16'd0;
  localparam logic [15:0] RST_GAIN_DIVISOR = 16'd1;
  localparam logic [8:0]  RST_MIN_DRIVE    = 9'd0;
  localparam logic        RST_INVERT       = 1'b0;

  // Output and term limits.
  localparam logic [ACC_W-1:0] OUT_MAX = 16'd65534;
  localparam logic signed [INTEG_W-1:0] INTEG_LIM = 18'sd1000;
  localparam logic [9:0]  P_LIM      = 10'd512;
  localparam logic [8:0]  I_LIM      = 9'd256;
  localparam logic [10:0] D_LIM      = 11'd1024;
  localparam logic [8:0]  ROUND_HALF = 9'd128;

  // Default derivative lag, in samples.
  localparam int DERIV_LAG_DEF = 1;

endpackage

// ===== rtl/core/incremental_pid_with_deadband.sv =====
// Incremental PID controller with deadband, top level.
// Depends on ipd_pkg for constants; contains the sequencer and shared datapath.
//
// One measurement word is taken at a time. Each word goes from acceptance to the
// deadband check; outside the band it goes straight to the result (the deadband
// path), inside it the PID path runs the shared 17x16 multiplier and the one
// compare-subtract divider stage, which produces one quotient bit a cycle: 10
// steps for the P term and 9 for the I term. in_ready is high only while the
// block is idle; the result word is held until it is taken. Configuration writes
// take effect at once and must only be issued while idle.
module incremental_pid_with_deadband #(
  parameter int DERIV_LAG = ipd_pkg::DERIV_LAG_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [ipd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ipd_pkg::CFG_DAT_W-1:0]     cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [ipd_pkg::MEAS_W-1:0] in_measurement,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ipd_pkg::DRIVE_W-1:0]       out_drive,
  output logic [ipd_pkg::ACC_W-1:0]         out_accumulated_output
);
  import ipd_pkg::*;

  localparam int LAG = (DERIV_LAG > 2) ? 2 : ((DERIV_LAG < 1) ? 1 : DERIV_LAG);

  // Sequencer codes.
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_CHK  = 4'd1;
  localparam logic [3:0] ST_MULP = 4'd2;
  localparam logic [3:0] ST_DIVP = 4'd3;
  localparam logic [3:0] ST_MULI = 4'd4;
  localparam logic [3:0] ST_DIVI = 4'd5;
  localparam logic [3:0] ST_MULD = 4'd6;
  localparam logic [3:0] ST_SUM  = 4'd7;
  localparam logic [3:0] ST_OUT  = 4'd8;

  // Configuration registers.
  logic signed [15:0] setpoint_r;
  logic [15:0]        deadband_r;
  logic [15:0]        kp_r;
  logic [7:0]         ki_r;
  logic [15:0]        kd_r;
  logic [15:0]        gain_div_r;
  logic [8:0]         min_drive_r;
  logic               invert_r;

  // Control and datapath state.
  logic [3:0]                state_r, state_nxt;
  logic signed [ERR_W-1:0]   err_r, err_nxt;
  logic signed [ERR_W-1:0]   hist_r [0:LAG];
  logic signed [INTEG_W-1:0] integ_r, integ_nxt;
  logic [ACC_W-1:0]          acc_r, acc_nxt;
  logic [32:0]               rem_r, rem_nxt;
  logic [24:0]               dsh_r, dsh_nxt;
  logic [9:0]                q_r, q_nxt;
  logic [3:0]                cnt_r, cnt_nxt;
  logic                      sgn_r, sgn_nxt;
  logic signed [10:0]        p_r, p_nxt;
  logic signed [9:0]         i_r, i_nxt;
  logic                      shift_hist;

  // Combinational helpers.
  logic signed [ERR_W-1:0]   err_in;
  logic signed [ERR_W:0]     err_x, db_pos, db_neg;
  logic signed [ERR_W-1:0]   err_abs;
  logic signed [INTEG_W-1:0] integ_abs;
  logic signed [ERR_W:0]     diff, diff_abs;
  logic [15:0]               div_eff;
  logic [16:0]               mul_a;
  logic [15:0]               mul_b;
  logic                      mul_s;
  logic [32:0]               prod;
  logic                      ge;
  logic [32:0]               dsh_ext;
  logic [9:0]                pmag;
  logic [8:0]                imag;
  logic [10:0]               dmag;
  logic signed [18:0]        sum;
  logic [16:0]               rounded;

  // Configuration write port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r  <= RST_SETPOINT;
      deadband_r  <= RST_DEADBAND;
      kp_r        <= RST_KP;
      ki_r        <= RST_KI;
      kd_r        <= RST_KD;
      gain_div_r  <= RST_GAIN_DIVISOR;
      min_drive_r <= RST_MIN_DRIVE;
      invert_r    <= RST_INVERT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SETPOINT:     setpoint_r  <= cfg_wdata;
        REG_DEADBAND:     deadband_r  <= cfg_wdata;
        REG_KP:           kp_r        <= cfg_wdata;
        REG_KI:           ki_r        <= cfg_wdata[7:0];
        REG_KD:           kd_r        <= cfg_wdata;
        REG_GAIN_DIVISOR: gain_div_r  <= cfg_wdata;
        REG_MIN_DRIVE:    min_drive_r <= cfg_wdata[8:0];
        REG_INVERT:       invert_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Error of the incoming word, with optional inversion of sense.
  always_comb begin
    if (invert_r) begin
      err_in = ERR_W'(in_measurement) - ERR_W'(setpoint_r);
    end else begin
      err_in = ERR_W'(setpoint_r) - ERR_W'(in_measurement);
    end
  end

  // Deadband limits and operand magnitudes.
  assign err_x     = {err_r[ERR_W-1], err_r};
  assign db_pos    = $signed({2'b00, deadband_r});
  assign db_neg    = -db_pos;
  assign err_abs   = err_r[ERR_W-1] ? -err_r : err_r;
  assign integ_abs = integ_r[INTEG_W-1] ? -integ_r : integ_r;
  assign diff      = {hist_r[0][ERR_W-1], hist_r[0]} - {hist_r[LAG][ERR_W-1], hist_r[LAG]};
  assign diff_abs  = diff[ERR_W] ? -diff : diff;
  assign div_eff   = (gain_div_r == 16'd0) ? 16'd1 : gain_div_r;

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    mul_s = 1'b0;
    case (state_r)
      ST_MULP: begin
        mul_a = err_abs;
        mul_b = kp_r;
        mul_s = err_r[ERR_W-1];
      end
      ST_MULI: begin
        mul_a = integ_abs[16:0];
        mul_b = {8'd0, ki_r};
        mul_s = integ_r[INTEG_W-1];
      end
      ST_MULD: begin
        mul_a = diff_abs[16:0];
        mul_b = kd_r;
        mul_s = diff[ERR_W];
      end
      default: ;
    endcase
  end

  assign prod = mul_a * mul_b;

  // Shared compare-subtract stage of the divider.
  assign dsh_ext = {8'd0, dsh_r};
  assign ge      = rem_r >= dsh_ext;

  // Term bounds and output sum.
  assign dmag = (rem_r > {22'd0, D_LIM}) ? D_LIM : rem_r[10:0];
  assign sum  = $signed({3'b000, acc_r}) + 19'(p_r) + 19'(i_r)
              + (sgn_r ? -$signed({8'd0, dmag}) : $signed({8'd0, dmag}));

  // Sequencer and datapath next values.
  always_comb begin
    state_nxt  = state_r;
    err_nxt    = err_r;
    integ_nxt  = integ_r;
    acc_nxt    = acc_r;
    rem_nxt    = rem_r;
    dsh_nxt    = dsh_r;
    q_nxt      = q_r;
    cnt_nxt    = cnt_r;
    sgn_nxt    = sgn_r;
    p_nxt      = p_r;
    i_nxt      = i_r;
    shift_hist = 1'b0;
    pmag       = '0;
    imag       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          err_nxt   = err_in;
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        if (err_x > db_pos) begin
          acc_nxt   = OUT_MAX;
          state_nxt = ST_OUT;
        end else if (err_x < db_neg) begin
          acc_nxt   = '0;
          state_nxt = ST_OUT;
        end else begin
          shift_hist = 1'b1;
          // Clear on a sign change or zero error, else grow while bounded.
          if ((err_r > 0 && hist_r[0] < 0) || (err_r < 0 && hist_r[0] > 0) ||
              err_r == 0) begin
            integ_nxt = '0;
          end else if (integ_r < INTEG_LIM && integ_r > -INTEG_LIM) begin
            integ_nxt = integ_r + INTEG_W'(err_r);
          end
          state_nxt = ST_MULP;
        end
      end
      ST_MULP: begin
        rem_nxt   = prod;
        sgn_nxt   = mul_s;
        dsh_nxt   = {div_eff, 9'd0};
        q_nxt     = '0;
        cnt_nxt   = 4'd9;
        state_nxt = ST_DIVP;
      end
      ST_DIVP, ST_DIVI: begin
        rem_nxt = ge ? (rem_r - dsh_ext) : rem_r;
        q_nxt   = {q_r[8:0], ge};
        dsh_nxt = dsh_r >> 1;
        cnt_nxt = cnt_r - 4'd1;
        if (cnt_r == 4'd0) begin
          if (state_r == ST_DIVP) begin
            pmag      = q_nxt[9] ? P_LIM : q_nxt;
            p_nxt     = sgn_r ? -$signed({1'b0, pmag}) : $signed({1'b0, pmag});
            state_nxt = ST_MULI;
          end else begin
            imag      = q_nxt[8] ? I_LIM : q_nxt[8:0];
            i_nxt     = sgn_r ? -$signed({1'b0, imag}) : $signed({1'b0, imag});
            state_nxt = ST_MULD;
          end
        end
      end
      ST_MULI: begin
        rem_nxt   = prod;
        sgn_nxt   = mul_s;
        dsh_nxt   = {1'b0, div_eff, 8'd0};
        q_nxt     = '0;
        cnt_nxt   = 4'd8;
        state_nxt = ST_DIVI;
      end
      ST_MULD: begin
        rem_nxt   = prod;
        sgn_nxt   = mul_s;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        if (sum > $signed({3'b000, OUT_MAX})) begin
          acc_nxt = OUT_MAX;
        end else if (sum < 0) begin
          acc_nxt = '0;
        end else begin
          acc_nxt = sum[ACC_W-1:0];
        end
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state and persistent controller state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      integ_r <= '0;
      acc_r   <= '0;
      for (int k = 0; k <= LAG; k++) begin
        hist_r[k] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      integ_r <= integ_nxt;
      acc_r   <= acc_nxt;
      if (shift_hist) begin
        hist_r[0] <= err_r;
        for (int k = 1; k <= LAG; k++) begin
          hist_r[k] <= hist_r[k-1];
        end
      end
    end
  end

  // Working registers of the shared unit.
  always_ff @(posedge clk) begin
    err_r <= err_nxt;
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
    sgn_r <= sgn_nxt;
    p_r   <= p_nxt;
    i_r   <= i_nxt;
  end

  // Handshake and result word.
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign rounded   = {1'b0, acc_r} + {8'd0, ROUND_HALF};
  assign out_drive = (rounded[16:8] < min_drive_r) ? '0 : acc_r[15:8];
  assign out_accumulated_output = acc_r;

endmodule

// ===== sim/tb_incremental_pid_with_deadband.sv =====
// Self-checking testbench for the incremental PID controller with deadband.
// Holds a table of directed samples, random phases under several settings and an
// in-bench predictor of the control law. Depends on ipd_pkg and the block itself.
module tb_incremental_pid_with_deadband;
  import ipd_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int N_DIRECTED   = 16;
  localparam int N_PHASES     = 10;
  localparam int PHASE_ITEMS  = 50;
  localparam int SETTLE_WAIT  = 30;
  localparam int D_LAG        = (DERIV_LAG_DEF > 2) ? 2 : DERIV_LAG_DEF;

  // One result word: the reported byte and the full output level.
  typedef struct packed {
    logic [DRIVE_W-1:0] drive;
    logic [ACC_W-1:0]   level;
  } drive_word_t;

  // One directed sample, with its result typed in where it is obvious.
  typedef struct packed {
    logic signed [MEAS_W-1:0] sample;
    logic                     known;
    logic [DRIVE_W-1:0]       drive;
    logic [ACC_W-1:0]         level;
  } directed_row_t;

  // Receiver stall styles.
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_BURSTY} rx_style_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = REG_SETPOINT;
  logic [CFG_DAT_W-1:0]     cfg_wdata = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [MEAS_W-1:0] in_measurement = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [DRIVE_W-1:0]       out_drive;
  logic [ACC_W-1:0]         out_accumulated_output;

  // Predictor copy of the registers.
  logic signed [MEAS_W-1:0] set_point;
  logic [15:0]              dead_band;
  logic [15:0]              gain_p;
  logic [7:0]               gain_i;
  logic [15:0]              gain_d;
  logic [15:0]              gain_div;
  logic [8:0]               min_lvl;
  logic                     inv_sense;

  // Predictor copy of the controller state.
  logic signed [ERR_W-1:0]   err_hist [3];
  logic signed [INTEG_W-1:0] integ_sum;
  logic [ACC_W-1:0]          acc_level;

  drive_word_t pending_drive [$];
  drive_word_t head_word;
  int          error_count = 0;
  int          cycle_count = 0;
  int          burst_left = 0;
  int          streak_sign = 1;
  int          ready_tick = 0;
  rx_style_t   rx_style = RX_OPEN;

  directed_row_t directed_rows [N_DIRECTED] = '{
    '{16'sh0000, 1'b1, 8'd0,   16'd0},
    '{16'sh8000, 1'b1, 8'd255, 16'd65534},
    '{16'sh7FFF, 1'b1, 8'd0,   16'd0},
    '{16'sh8000, 1'b1, 8'd255, 16'd65534},
    '{16'sd100,  1'b0, 8'd0,   16'd0},
    '{-16'sd100, 1'b0, 8'd0,   16'd0},
    '{-16'sd101, 1'b1, 8'd255, 16'd65534},
    '{16'sd101,  1'b1, 8'd0,   16'd0},
    '{-16'sd50,  1'b0, 8'd0,   16'd0},
    '{-16'sd60,  1'b0, 8'd0,   16'd0},
    '{-16'sd70,  1'b0, 8'd0,   16'd0},
    '{16'sd0,    1'b0, 8'd0,   16'd0},
    '{16'sd30,   1'b0, 8'd0,   16'd0},
    '{16'sh5555, 1'b1, 8'd0,   16'd0},
    '{16'shAAAA, 1'b1, 8'd255, 16'd65534},
    '{16'sd1,    1'b0, 8'd0,   16'd0}
  };

  incremental_pid_with_deadband u_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_measurement         (in_measurement),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_drive              (out_drive),
    .out_accumulated_output (out_accumulated_output)
  );

  always #5 clk = ~clk;

  // Registers and state as they stand after reset.
  function automatic void reset_pid_model();
    set_point = RST_SETPOINT;
    dead_band = RST_DEADBAND;
    gain_p    = RST_KP;
    gain_i    = RST_KI;
    gain_d    = RST_KD;
    gain_div  = RST_GAIN_DIVISOR;
    min_lvl   = RST_MIN_DRIVE;
    inv_sense = RST_INVERT;
    err_hist[0] = '0;
    err_hist[1] = '0;
    err_hist[2] = '0;
    integ_sum = '0;
    acc_level = '0;
  endfunction

  function automatic longint clamp_mag(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Advance the controller by one sample and return the word it reports.
  function automatic drive_word_t advance_pid(input logic signed [MEAS_W-1:0] m);
    longint      e, db, dv, integ, p, i, d, total;
    drive_word_t w;
    e  = inv_sense ? (longint'(m) - longint'(set_point))
                   : (longint'(set_point) - longint'(m));
    db = longint'(dead_band);
    if (e > db) begin
      acc_level = OUT_MAX;
    end else if (e < -db) begin
      acc_level = '0;
    end else begin
      dv = (gain_div == 16'd0) ? 1 : longint'(gain_div);
      err_hist[2] = err_hist[1];
      err_hist[1] = err_hist[0];
      err_hist[0] = e[ERR_W-1:0];
      // A sign change or a zero error clears the integral; otherwise it grows
      // only while it is inside the window.
      integ = longint'(integ_sum);
      if ((e > 0 && err_hist[1] < 0) || (e < 0 && err_hist[1] > 0) || e == 0) begin
        integ = 0;
      end else if (integ < 1000 && integ > -1000) begin
        integ = integ + e;
      end
      integ_sum = integ[INTEG_W-1:0];
      p = clamp_mag((longint'(gain_p) * e) / dv, 512);
      i = clamp_mag((longint'(gain_i) * integ) / dv, 256);
      d = clamp_mag(longint'(gain_d) * (e - longint'(err_hist[D_LAG])), 1024);
      total = longint'(acc_level) + p + i + d;
      if (total > 65534) acc_level = OUT_MAX;
      else if (total < 0) acc_level = '0;
      else acc_level = total[ACC_W-1:0];
    end
    w.level = acc_level;
    if ((longint'(acc_level) + 128) / 256 < longint'(min_lvl)) w.drive = '0;
    else w.drive = acc_level[15:8];
    return w;
  endfunction

  // Write one register, in the block and in the predictor.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_SETPOINT:     set_point = data;
      REG_DEADBAND:     dead_band = data;
      REG_KP:           gain_p = data;
      REG_KI:           gain_i = data[7:0];
      REG_KD:           gain_d = data;
      REG_GAIN_DIVISOR: gain_div = data;
      REG_MIN_DRIVE:    min_lvl = data[8:0];
      REG_INVERT:       inv_sense = data[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [15:0] sp, input logic [15:0] db,
                                input logic [15:0] kp, input logic [15:0] ki,
                                input logic [15:0] kd, input logic [15:0] div,
                                input logic [15:0] mind, input logic [15:0] inv);
    write_reg(REG_SETPOINT, sp);
    write_reg(REG_DEADBAND, db);
    write_reg(REG_KP, kp);
    write_reg(REG_KI, ki);
    write_reg(REG_KD, kd);
    write_reg(REG_GAIN_DIVISOR, div);
    write_reg(REG_MIN_DRIVE, mind);
    write_reg(REG_INVERT, inv);
    cfg_we <= 1'b0;
  endtask

  // Random settings for one phase, weighted toward gains that keep the loop
  // inside its range.
  task automatic random_settings();
    logic [15:0] db, kp, kd, div;
    case ($urandom_range(0, 3))
      0: db = 16'($urandom_range(0, 20));
      1: db = 16'($urandom_range(20, 500));
      2: db = 16'($urandom_range(500, 5000));
      default: db = 16'($urandom_range(0, 65535));
    endcase
    case ($urandom_range(0, 2))
      0: kp = 16'($urandom_range(0, 4));
      1: kp = 16'($urandom_range(0, 300));
      default: kp = 16'($urandom_range(0, 65535));
    endcase
    kd = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                     : 16'($urandom_range(0, 8));
    case ($urandom_range(0, 4))
      0: div = 16'($urandom_range(1, 4));
      1: div = 16'($urandom_range(1, 300));
      2: div = 16'd0;
      default: div = 16'($urandom_range(1, 65535));
    endcase
    apply_settings(16'($urandom_range(0, 65535)), db, kp, 16'($urandom_range(0, 255)),
                   kd, div, 16'($urandom_range(0, 256)), 16'($urandom_range(0, 1)));
  endtask

  // Pick a sample: mostly inside the deadband with streaks of one error sign,
  // some at the band edges and some fully random.
  function automatic logic signed [MEAS_W-1:0] pick_sample();
    longint off, lim, m;
    int     r;
    r = $urandom_range(0, 99);
    if (r < 15) return 16'($urandom_range(0, 65535));
    if (r < 22) begin
      off = longint'(dead_band) + $urandom_range(0, 1);
      if ($urandom_range(0, 1) == 1) off = -off;
    end else begin
      if ($urandom_range(0, 7) == 0) streak_sign = -streak_sign;
      lim = (dead_band > 400) ? 400 : longint'(dead_band);
      off = streak_sign * longint'($urandom_range(0, int'(lim)));
      if ($urandom_range(0, 15) == 0) off = 0;
    end
    m = inv_sense ? longint'(set_point) + off : longint'(set_point) - off;
    if (m > 32767) m = 32767;
    if (m < -32768) m = -32768;
    return m[MEAS_W-1:0];
  endfunction

  // Offer one word and wait until it is taken; valid is left high.
  task automatic send_sample(input logic signed [MEAS_W-1:0] m, input logic known,
                             input drive_word_t known_word);
    drive_word_t w;
    in_valid       <= 1'b1;
    in_measurement <= m;
    do @(posedge clk); while (!in_ready);
    w = advance_pid(m);
    pending_drive.push_back(known ? known_word : w);
  endtask

  // Sender pacing: bursts of back-to-back words with random gaps between.
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 45);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Let every expected word arrive and the block fall idle.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_drive.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  // Receiver stall pattern, switching style now and then.
  always @(posedge clk) begin
    ready_tick <= ready_tick + 1;
    if (ready_tick % 97 == 0) rx_style <= rx_style_t'($urandom_range(0, 3));
    case (rx_style)
      RX_OPEN:   out_ready <= 1'b1;
      RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready <= (ready_tick % 5 == 0);
      default:   out_ready <= ((ready_tick / 8) % 2 == 0);
    endcase
  end

  // Compare each word taken from the block with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_drive.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual drive %0d level %0d",
                 $time, out_drive, out_accumulated_output);
        error_count++;
      end else begin
        head_word = pending_drive.pop_front();
        if (out_drive !== head_word.drive) begin
          $display("%0t: drive mismatch, expected %0d, actual %0d",
                   $time, head_word.drive, out_drive);
          error_count++;
        end
        if (out_accumulated_output !== head_word.level) begin
          $display("%0t: accumulated output mismatch, expected %0d, actual %0d",
                   $time, head_word.level, out_accumulated_output);
          error_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    reset_pid_model();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed samples under the reset settings.
    for (int k = 0; k < N_DIRECTED; k++) begin
      send_sample(directed_rows[k].sample, directed_rows[k].known,
                  '{drive: directed_rows[k].drive, level: directed_rows[k].level});
      pace_sender();
    end

    // Phases under extreme and then random settings.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      settle();
      case (ph)
        0: apply_settings(16'h0000, 16'hFFFF, 16'hFFFF, 16'h00FF,
                          16'hFFFF, 16'd1, 16'd0, 16'd0);
        1: apply_settings(16'h8000, 16'h0000, 16'h0000, 16'h0000,
                          16'h0000, 16'hFFFF, 16'd256, 16'd1);
        2: apply_settings(16'h7FFF, 16'hFFFF, 16'd1, 16'd1,
                          16'd1, 16'd0, 16'd511, 16'd1);
        default: random_settings();
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        send_sample(pick_sample(), 1'b0, '0);
        pace_sender();
      end
    end

    in_valid <= 1'b0;
    while (pending_drive.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
